/* design/bdlp_pkg.sv */
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debounce / long press block.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int NUM_KEYS   = 6;
    localparam int SLOT_COUNT = 3;
    localparam int MS_W       = 32;
    localparam int LPT_W      = 16;
    localparam int SCAN_W     = 8;

    // Slot index value that selects the vote instead of a sample store
    localparam logic [1:0] VOTE_SLOT = 2'(SLOT_COUNT);

    localparam logic [2:0] FIRST_KEY = 3'd0;
    localparam logic [2:0] ENTER_KEY = 3'd5;

    localparam logic [LPT_W-1:0]  LONG_PRESS_RESET  = 16'd1000;
    localparam logic [SCAN_W-1:0] SCAN_PERIOD_RESET = 8'd5;

    // Configuration register indexes
    localparam logic CFG_LONG_PRESS  = 1'b0;
    localparam logic CFG_SCAN_PERIOD = 1'b1;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_SHORT = 2'd1;
    localparam logic [1:0] REQ_LONG  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [NUM_KEYS-1:0] raw_keys;
        logic [2:0]          key_index;
    } t_req;

    typedef struct packed {
        logic                event_flag;
        logic [NUM_KEYS-1:0] debounced_keys;
    } t_rsp;

    typedef struct packed {
        logic scan;
        logic key_down;
        logic rd_short;
        logic rd_long;
    } t_lane_cmd;

    typedef struct packed {
        logic short_pend;
        logic long_pend;
    } t_lane_stat;

endpackage

/* design/bdlp_stream_if.sv */
// ----------------------------------------------------------------------------
// bdlp_stream_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface bdlp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* design/bdlp_scan.sv */
// ----------------------------------------------------------------------------
// bdlp_scan
// Scan divider, three sample slots and the per-bit majority vote.
// ----------------------------------------------------------------------------
module bdlp_scan
    import bdlp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic [NUM_KEYS-1:0] i_raw,
    input  logic [SCAN_W-1:0]   i_scan_period,
    output logic                o_scan,
    output logic [NUM_KEYS-1:0] o_voted_next,
    output logic [NUM_KEYS-1:0] o_voted
);

    logic [SCAN_W-1:0]   r_divider;
    logic [NUM_KEYS-1:0] r_slots [SLOT_COUNT];
    logic [1:0]          r_slot_idx;
    logic [NUM_KEYS-1:0] r_voted;

    logic [SCAN_W:0]     w_div_inc;
    logic [NUM_KEYS-1:0] w_vote;

    assign w_div_inc = {1'b0, r_divider} + (SCAN_W+1)'(1);
    assign o_scan    = i_tick && (w_div_inc > {1'b0, i_scan_period});
    assign w_vote    = (r_slots[0] & r_slots[1]) | (r_slots[1] & r_slots[2])
                     | (r_slots[2] & r_slots[0]);

    assign o_voted_next = (o_scan && r_slot_idx == VOTE_SLOT) ? w_vote : r_voted;
    assign o_voted      = r_voted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider  <= '0;
            r_slot_idx <= '0;
            r_voted    <= '0;
        end else begin
            r_voted <= o_voted_next;
            if (i_tick) begin
                r_divider <= o_scan ? '0 : w_div_inc[SCAN_W-1:0];
            end
            if (o_scan) begin
                r_slot_idx <= (r_slot_idx == VOTE_SLOT) ? 2'd0 : r_slot_idx + 2'd1;
            end
        end
    end

    // Slots are always fully written before the first vote reads them
    always_ff @(posedge i_clk) begin
        if (o_scan && r_slot_idx != VOTE_SLOT) begin
            r_slots[r_slot_idx] <= i_raw;
        end
    end

endmodule

/* design/bdlp_lane.sv */
// ----------------------------------------------------------------------------
// bdlp_lane
// Press tracking of one key: held mark, deadline, short and long flags.
// ----------------------------------------------------------------------------
module bdlp_lane
    import bdlp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lane_cmd        i_cmd,
    input  logic [MS_W-1:0]  i_now,
    input  logic [MS_W-1:0]  i_arm,
    output t_lane_stat       o_stat
);

    logic            r_mark;
    logic            r_short;
    logic            r_long;
    logic [MS_W-1:0] r_deadline;

    logic [MS_W-1:0] w_dl_eff;
    logic            w_due;

    // A fresh press arms the deadline before the due check
    assign w_dl_eff = r_mark ? r_deadline : i_arm;
    assign w_due    = w_dl_eff <= i_now;

    assign o_stat.short_pend = r_short;
    assign o_stat.long_pend  = r_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= 1'b0;
            r_short <= 1'b0;
            r_long  <= 1'b0;
        end else begin
            priority if (i_cmd.scan) begin
                if (i_cmd.key_down) begin
                    r_mark <= 1'b1;
                    if (w_due) begin
                        r_long <= 1'b1;
                    end
                end else begin
                    if (r_mark && !r_short) begin
                        r_short <= 1'b1;
                        r_mark  <= 1'b0;
                    end
                    r_long <= 1'b0;
                end
            end else if (i_cmd.rd_short) begin
                r_short <= 1'b0;
            end else if (i_cmd.rd_long) begin
                r_long <= 1'b0;
            end else begin
                r_mark <= r_mark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && i_cmd.key_down && (w_due || !r_mark)) begin
            r_deadline <= i_arm;
        end
    end

endmodule

/* design/button_debounce_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_long_press
// Six-key debouncer with short and long press event flags.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries request words: a one-millisecond tick with the raw key
//   levels, or a read of one key's short or long press flag. Every request
//   word yields exactly one response word on o_rsp: the event flag (always
//   zero for ticks) and the debounced key levels after the request.
//   Flow: an accepted word waits in the input register; single-pass update
//   logic then writes its response into the response register, which
//   drives o_rsp. While o_rsp does not stall, one word per cycle is
//   sustained, so throughput is one word per clock.
//   When o_rsp stalls, the response register holds and the input register
//   keeps one more word; i_req.ready drops only when both are full.
//   Reset clears all flags, the counters and the vote and loads the
//   configuration defaults (long press 1000 ms, scan period 5).
//   Configuration writes are taken whenever i_cfg_we is high; write them
//   only while no request is in flight.
// ----------------------------------------------------------------------------
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [LPT_W-1:0]  i_cfg_data,
    bdlp_stream_if.sink       i_req,
    bdlp_stream_if.source     o_rsp
);

    // Configuration
    logic [LPT_W-1:0]  r_long_press;
    logic [SCAN_W-1:0] r_scan_period;

    // Input register and response register
    logic r_in_valid;
    t_req r_in_item;
    logic r_out_valid;
    t_rsp r_out_item;

    // Incremented millisecond count: the value a tick sees after its advance
    logic [MS_W-1:0] r_ms_next;
    logic            r_suppress;

    logic                w_fire;
    logic                w_key_ok;
    logic                w_tick;
    logic                w_rd_short;
    logic                w_rd_long;
    logic                w_scan;
    logic                w_special;
    logic                w_sp;
    logic                w_lp;
    logic [NUM_KEYS-1:0] w_key_sel;
    logic [NUM_KEYS-1:0] w_voted_next;
    logic [NUM_KEYS-1:0] w_voted;
    logic [NUM_KEYS-1:0] w_short_pend;
    logic [NUM_KEYS-1:0] w_long_pend;
    logic [MS_W-1:0]     w_arm;
    logic                n_flag;
    logic                n_suppress;

    // Advance the pipe when the response slot is free or being drained
    assign w_fire      = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_fire;

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out_item;

    // Decode the held request
    assign w_key_ok   = r_in_item.key_index < 3'(NUM_KEYS);
    assign w_tick     = w_fire && r_in_item.req_type == REQ_TICK;
    assign w_rd_short = w_fire && r_in_item.req_type == REQ_SHORT && w_key_ok;
    assign w_rd_long  = w_fire && r_in_item.req_type == REQ_LONG && w_key_ok;
    assign w_special  = r_in_item.key_index == FIRST_KEY
                     || r_in_item.key_index == ENTER_KEY;

    always_comb begin
        for (int n = 0; n < NUM_KEYS; n++) begin
            w_key_sel[n] = r_in_item.key_index == 3'(n);
        end
    end

    assign w_sp  = |(w_short_pend & w_key_sel);
    assign w_lp  = |(w_long_pend & w_key_sel);
    assign w_arm = r_ms_next + MS_W'(r_long_press);

    // Scan divider, sample slots and majority vote
    bdlp_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (w_tick),
        .i_raw         (r_in_item.raw_keys),
        .i_scan_period (r_scan_period),
        .o_scan        (w_scan),
        .o_voted_next  (w_voted_next),
        .o_voted       (w_voted)
    );

    // One tracking lane per key
    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
        t_lane_cmd  w_cmd;
        t_lane_stat w_stat;

        assign w_cmd.scan     = w_scan;
        assign w_cmd.key_down = w_voted_next[g];
        assign w_cmd.rd_short = w_rd_short && w_key_sel[g];
        assign w_cmd.rd_long  = w_rd_long && w_key_sel[g];

        bdlp_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_now   (r_ms_next),
            .i_arm   (w_arm),
            .o_stat  (w_stat)
        );

        assign w_short_pend[g] = w_stat.short_pend;
        assign w_long_pend[g]  = w_stat.long_pend;
    end

    // Event flag and short suppression after a long read
    always_comb begin
        n_flag     = 1'b0;
        n_suppress = r_suppress;
        if (w_rd_short && w_sp) begin
            if (w_special && r_suppress) begin
                n_suppress = 1'b0;
            end else begin
                n_flag = 1'b1;
            end
        end
        if (w_rd_long && w_lp) begin
            n_suppress = 1'b1;
            n_flag     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press  <= LONG_PRESS_RESET;
            r_scan_period <= SCAN_PERIOD_RESET;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ms_next     <= MS_W'(1);
            r_suppress    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LONG_PRESS:  r_long_press  <= i_cfg_data;
                    CFG_SCAN_PERIOD: r_scan_period <= i_cfg_data[SCAN_W-1:0];
                endcase
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_tick) begin
                r_ms_next <= r_ms_next + MS_W'(1);
            end
            r_suppress <= n_suppress;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item <= i_req.payload;
        end
        if (w_fire) begin
            r_out_item.event_flag     <= n_flag;
            r_out_item.debounced_keys <= w_voted_next;
        end
    end

    // A held request is never overwritten before it is processed
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in_item))
        else $error("input register overwritten while stalled");

    // Ticks never raise an event
    a_tick_no_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> !r_out_item.event_flag)
        else $error("event flag set on a tick");

    // A consumed long press arms short suppression
    a_long_suppress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_long && w_lp |=> r_suppress && r_out_item.event_flag)
        else $error("long read did not arm suppression");

    // Reported levels match the vote register
    a_keys_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_item.debounced_keys == w_voted)
        else $error("debounced keys differ from vote");

endmodule

/* verif/tb_button_debounce_long_press.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_long_press
// Self-checking bench for the six-key debouncer. A scoreboard class mirrors
// the tick divider, three-slot majority vote, press tracking and flag reads,
// and checks every response word in order. Stimulus is held key patterns with
// random reads under several settings, with a directed section after the first stretch.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press;
    import bdlp_pkg::*;

    localparam logic [1:0] REQ_NONE      = 2'd3;   // unused request code
    localparam int         WATCHDOG_MAX  = 2000;   // quiet cycles before giving up
    localparam int         DRAIN_CYCLES  = 6;      // settle time past the last response
    localparam int         HOLD_OFF_LEN  = 80;     // long receiver stall, in cycles

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the block state and holds the expected responses
    // ------------------------------------------------------------------------
    class press_scoreboard;
        logic [LPT_W-1:0]    long_ticks;
        logic [SCAN_W-1:0]   scan_period;
        logic [MS_W-1:0]     ms_count;
        int unsigned         divider;
        logic [NUM_KEYS-1:0] slots [SLOT_COUNT];
        int unsigned         slot_sel;
        logic [NUM_KEYS-1:0] voted;
        logic [NUM_KEYS-1:0] held;
        logic [NUM_KEYS-1:0] short_pend;
        logic [NUM_KEYS-1:0] long_pend;
        logic [MS_W-1:0]     deadline [NUM_KEYS];
        bit                  suppress;
        t_rsp                expected_rsp_q [$];
        int                  errors;

        function new();
            long_ticks  = LONG_PRESS_RESET;
            scan_period = SCAN_PERIOD_RESET;
            ms_count    = '0;
            divider     = 0;
            slot_sel    = 0;
            voted       = '0;
            held        = '0;
            short_pend  = '0;
            long_pend   = '0;
            suppress    = 1'b0;
            errors      = 0;
            foreach (slots[i]) slots[i] = '0;
            foreach (deadline[i]) deadline[i] = '0;
        endfunction

        function void set_config(logic idx, logic [LPT_W-1:0] data);
            if (idx == CFG_LONG_PRESS)
                long_ticks = data;
            else
                scan_period = data[SCAN_W-1:0];
        endfunction

        // Per-key press tracking after a scan
        function void track_presses();
            for (int n = 0; n < NUM_KEYS; n++) begin
                if (voted[n]) begin
                    if (!held[n])
                        deadline[n] = ms_count + MS_W'(long_ticks);
                    held[n] = 1'b1;
                    if (deadline[n] <= ms_count) begin
                        long_pend[n] = 1'b1;
                        deadline[n]  = ms_count + MS_W'(long_ticks);
                    end
                end else begin
                    // a release with a short still pending keeps the mark
                    if (held[n] && !short_pend[n]) begin
                        short_pend[n] = 1'b1;
                        held[n]       = 1'b0;
                    end
                    long_pend[n] = 1'b0;
                end
            end
        endfunction

        // Advance the mirror by one accepted request word
        function void note_request(t_req w);
            t_rsp rsp;
            rsp.event_flag = 1'b0;
            case (w.req_type)
                REQ_TICK: begin
                    ms_count = ms_count + 1;
                    if (divider + 1 > scan_period) begin
                        if (slot_sel >= SLOT_COUNT) begin
                            voted = (slots[0] & slots[1]) | (slots[1] & slots[2])
                                  | (slots[2] & slots[0]);
                            slot_sel = 0;
                        end else begin
                            slots[slot_sel] = w.raw_keys;
                            slot_sel++;
                        end
                        track_presses();
                        divider = 0;
                    end else begin
                        divider = divider + 1;
                    end
                end
                REQ_SHORT: begin
                    if (w.key_index < NUM_KEYS && short_pend[w.key_index]) begin
                        short_pend[w.key_index] = 1'b0;
                        if ((w.key_index == FIRST_KEY || w.key_index == ENTER_KEY) && suppress)
                            suppress = 1'b0;
                        else
                            rsp.event_flag = 1'b1;
                    end
                end
                REQ_LONG: begin
                    if (w.key_index < NUM_KEYS && long_pend[w.key_index]) begin
                        long_pend[w.key_index] = 1'b0;
                        suppress       = 1'b1;
                        rsp.event_flag = 1'b1;
                    end
                end
                default: ;  // unused code: no state change
            endcase
            rsp.debounced_keys = voted;
            expected_rsp_q.push_back(rsp);
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            if (expected_rsp_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %p", got));
            end else begin
                want = expected_rsp_q.pop_front();
                if (got.event_flag !== want.event_flag)
                    report_mismatch($sformatf("event_flag got %b want %b",
                                              got.event_flag, want.event_flag));
                if (got.debounced_keys !== want.debounced_keys)
                    report_mismatch($sformatf("debounced_keys got %h want %h",
                                              got.debounced_keys, want.debounced_keys));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_LONG_PRESS;
    logic [LPT_W-1:0]  i_cfg_data = '0;

    bdlp_stream_if #(.T(t_req)) req_if ();
    bdlp_stream_if #(.T(t_rsp)) rsp_if ();

    press_scoreboard sb = new();

    int tx_idle_pct   = 0;   // chance in percent that the sender skips a cycle
    int rx_idle_pct   = 0;   // chance in percent that the receiver stalls a cycle
    int hold_off_left = 0;   // remaining cycles of a forced receiver stall
    int quiet_cycles  = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    button_debounce_long_press DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    initial begin
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
    end

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Note accepted requests before checking responses at the same edge;
    // a response never belongs to a request accepted at that edge.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.payload);
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.payload);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("button_debounce_long_press regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks; all are entered and left at a falling edge
    // ------------------------------------------------------------------------
    function automatic t_req mk_word(logic [1:0] req, logic [NUM_KEYS-1:0] raw,
                                     logic [2:0] key);
        t_req w;
        w.req_type  = req;
        w.raw_keys  = raw;
        w.key_index = key;
        return w;
    endfunction

    // Offer one word and hold it until the block takes it. Valid stays high
    // into the next word unless the sender decides to idle.
    task automatic send_word(t_req w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= w;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic play_words(ref t_req words [$]);
        foreach (words[i]) send_word(words[i]);
        req_if.valid <= 1'b0;
    endtask

    // Wait for every expected word, then let the pipeline settle
    task automatic wait_drained();
        while (sb.expected_rsp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Write both registers on consecutive edges; enable stays high across them
    task automatic load_settings(logic [LPT_W-1:0] long_ms, logic [SCAN_W-1:0] period);
        logic [LPT_W-1:0] period_word;
        period_word = {8'($urandom), period};  // upper byte is don't-care
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LONG_PRESS;
        i_cfg_data <= long_ms;
        @(posedge i_clk);
        sb.set_config(CFG_LONG_PRESS, long_ms);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_SCAN_PERIOD;
        i_cfg_data <= period_word;
        @(posedge i_clk);
        sb.set_config(CFG_SCAN_PERIOD, period_word);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Build a stretch of held key patterns with reads mixed in. Hold times
    // are scaled to whole votes so presses survive the majority filter.
    task automatic build_presses(int count, int period, ref t_req words [$]);
        logic [NUM_KEYS-1:0] pattern;
        logic [NUM_KEYS-1:0] raw;
        int                  hold_left;
        int                  pick;
        logic [1:0]          req;
        logic [2:0]          key;
        hold_left = 0;
        pattern   = '0;
        words.delete();
        repeat (count) begin
            if (hold_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       pattern = '0;
                    1:       pattern = NUM_KEYS'(1 << $urandom_range(0, NUM_KEYS - 1));
                    default: pattern = NUM_KEYS'($urandom_range(0, 63));
                endcase
                hold_left = (period + 1) * 4 * $urandom_range(1, 5);
            end
            pick = $urandom_range(0, 99);
            raw  = NUM_KEYS'($urandom_range(0, 63));
            key  = 3'($urandom_range(0, 7));
            if (pick < 60) begin
                req = REQ_TICK;
                raw = pattern;
                // flip one line now and then: a bounce the vote should reject
                if ($urandom_range(0, 9) == 0)
                    raw ^= NUM_KEYS'(1 << $urandom_range(0, NUM_KEYS - 1));
                hold_left--;
            end else if (pick < 96) begin
                req = $urandom_range(0, 1) ? REQ_SHORT : REQ_LONG;
                if ($urandom_range(0, 19) != 0)
                    key = 3'($urandom_range(0, NUM_KEYS - 1));
            end else begin
                req = REQ_NONE;
            end
            words.push_back(mk_word(req, raw, key));
        end
    endtask

    task automatic run_phase(int long_ms, int period, int count, int tx_pct, int rx_pct,
                             bit hold_off);
        t_req words [$];
        wait_drained();
        load_settings(LPT_W'(long_ms), SCAN_W'(period));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        build_presses(count, period, words);
        // stall the receiver while the sender keeps offering: input must back up
        if (hold_off)
            hold_off_left = HOLD_OFF_LEN;
        play_words(words);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        t_req script [$];
        int   leftover;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings untouched: checks the default scan period
        tx_idle_pct = 22;
        rx_idle_pct = 50;
        build_presses(15, 5, script);
        play_words(script);

        // Directed: zero long press time and zero scan period, so every tick
        // scans and a long event fires on the first vote that sees a key down
        wait_drained();
        load_settings('0, '0);
        script.delete();
        repeat (4) script.push_back(mk_word(REQ_TICK, 6'h3F, 3'd0));
        script.push_back(mk_word(REQ_LONG,  6'h00, FIRST_KEY));    // sets suppression
        script.push_back(mk_word(REQ_LONG,  6'h3F, ENTER_KEY));
        script.push_back(mk_word(REQ_LONG,  6'h00, 3'(NUM_KEYS + 1)));
        repeat (4) script.push_back(mk_word(REQ_TICK, 6'h00, 3'd7));
        script.push_back(mk_word(REQ_SHORT, 6'h00, FIRST_KEY));    // swallowed
        script.push_back(mk_word(REQ_SHORT, 6'h00, ENTER_KEY));    // reported
        script.push_back(mk_word(REQ_SHORT, 6'h3F, FIRST_KEY));    // already consumed
        script.push_back(mk_word(REQ_SHORT, 6'h00, 3'(NUM_KEYS)));
        script.push_back(mk_word(REQ_NONE,  6'h3F, 3'd3));
        script.push_back(mk_word(REQ_LONG,  6'h00, 3'd1));         // cleared by release
        script.push_back(mk_word(REQ_SHORT, 6'h00, 3'd4));
        repeat (3) script.push_back(mk_word(REQ_TICK, 6'h15, 3'd2));
        script.push_back(mk_word(REQ_TICK,  6'h2A, 3'd2));         // vote tick: raw unused
        script.push_back(mk_word(REQ_LONG,  6'h00, 3'd2));
        script.push_back(mk_word(REQ_SHORT, 6'h00, 3'd2));
        play_words(script);

        // Widest period: the divider climbs high, then the period drops under it
        run_phase(65535, 255, 25, 22, 50, 1'b0);
        run_phase(1, 1, 120, 22, 50, 1'b1);
        run_phase(12, 0, 120, 22, 50, 1'b0);
        run_phase(30, 2, 110, 50, 22, 1'b0);
        run_phase(65535, 0, 90, 50, 22, 1'b0);
        run_phase(5, 1, 120, 0, 0, 1'b0);

        wait_drained();
        leftover = sb.expected_rsp_q.size();
        if (leftover != 0)
            sb.report_mismatch($sformatf("%0d expected words never arrived", leftover));
        if (sb.errors == 0)
            $display("button_debounce_long_press regression: pass");
        else
            $display("button_debounce_long_press regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/bdlp_pkg.sv
design/bdlp_stream_if.sv
design/bdlp_scan.sv
design/bdlp_lane.sv
design/button_debounce_long_press.sv
verif/tb_button_debounce_long_press.sv
